>>> src/r10u_pkg.sv
// Shared types and constants for the RAW10 packed pixel unpacker.
package r10u_pkg;

	localparam int CFG_W        = 14;
	localparam int BYTE_W       = 8;
	localparam int PIX_W        = 10;
	localparam int LOW_W        = 2;
	localparam int GROUP_PIXELS = 4;
	localparam int PHASE_W      = 3;
	localparam int IDX_W        = 2;
	localparam int REG_IDX_W    = 1;

	localparam int DEF_MAX_WIDTH  = 8192;
	localparam int DEF_MAX_HEIGHT = 8192;

	localparam logic [CFG_W-1:0] RESET_LINE_WIDTH   = 14'd1456;
	localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 14'd1088;

	localparam logic [PHASE_W-1:0] PHASE_LOW_BYTE = 3'd4;

	localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [GROUP_PIXELS-1:0][PIX_W-1:0] pix;
		logic [IDX_W-1:0]                   last_idx;
		logic                               eol;
		logic                               eof;
	} group_t;

endpackage

>>> src/r10u_front.sv
// Byte collector that assembles five-byte groups and classifies them against the line geometry.
module r10u_front
	import r10u_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [CFG_W-1:0]  line_width,
	input  logic [CFG_W-1:0]  frame_height,
	input  logic              q_full,
	output logic              push,
	output group_t            grp
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int EW = ((CW > CFG_W) ? CW : CFG_W) + 1;
	localparam int EH = ((RW > CFG_W) ? RW : CFG_W) + 1;

	logic [PHASE_W-1:0]             phase_q;
	logic [GROUP_PIXELS-1:0][BYTE_W-1:0] held_q;
	logic [CW-1:0]                  col_q;
	logic [RW-1:0]                  row_q;
	logic [CW-1:0]                  width_eff;
	logic [RW-1:0]                  height_eff;
	logic [CW-1:0]                  remain;
	logic                           low_byte;
	logic                           accept;

	assign low_byte = (phase_q == PHASE_LOW_BYTE);
	assign in_ready = !low_byte || !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && low_byte;

	always_comb begin
		if (line_width == '0) begin
			width_eff = CW'(1);
		end else if ({{(EW-CFG_W){1'b0}}, line_width} > EW'(MAX_WIDTH)) begin
			width_eff = CW'(MAX_WIDTH);
		end else begin
			width_eff = CW'(line_width);
		end
		if (frame_height == '0) begin
			height_eff = RW'(1);
		end else if ({{(EH-CFG_W){1'b0}}, frame_height} > EH'(MAX_HEIGHT)) begin
			height_eff = RW'(MAX_HEIGHT);
		end else begin
			height_eff = RW'(frame_height);
		end
	end

	always_comb begin
		remain = width_eff - col_q;
		for (int k = 0; k < GROUP_PIXELS; k++) begin
			grp.pix[k] = {held_q[k], data_byte[LOW_W*k +: LOW_W]};
		end
		if (col_q >= width_eff) begin
			grp.last_idx = '0;
			grp.eol      = 1'b1;
		end else if (remain <= CW'(GROUP_PIXELS)) begin
			grp.last_idx = IDX_W'(remain - CW'(1));
			grp.eol      = 1'b1;
		end else begin
			grp.last_idx = IDX_W'(GROUP_PIXELS - 1);
			grp.eol      = 1'b0;
		end
		grp.eof = grp.eol && (({1'b0, row_q} + (RW+1)'(1)) >= {1'b0, height_eff});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (accept) begin
			if (low_byte) begin
				phase_q <= '0;
				if (grp.eol) begin
					col_q <= '0;
					row_q <= grp.eof ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(GROUP_PIXELS);
				end
			end else begin
				phase_q <= phase_q + PHASE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !low_byte) begin
			held_q[phase_q[IDX_W-1:0]] <= data_byte;
		end
	end

	a_eof_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(push && grp.eof) |=> (col_q == '0 && row_q == '0))
		else $error("counts not cleared after end of frame");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && low_byte) |=> (phase_q == '0))
		else $error("byte phase did not return to the start of a group");

endmodule

>>> src/r10u_queue.sv
// Two-entry register queue carrying classified groups from the front to the back.
module r10u_queue
	import r10u_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t push_grp,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output group_t head
);

	group_t      mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !not_empty))
		else $error("queue written when full or read when empty");

endmodule

>>> src/r10u_back.sv
// Pixel emitter walking each queued group, one word per cycle unless stalled.
module r10u_back
	import r10u_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  group_t           q_head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] pixel,
	output logic             last_of_run,
	output logic             end_of_line,
	output logic             end_of_frame
);

	group_t           cur_q;
	logic             cur_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic             at_last;
	logic             done;

	assign at_last      = (idx_q == cur_q.last_idx);
	assign done         = out_ready && at_last;
	assign pop          = q_not_empty && (!cur_valid_q || done);
	assign out_valid    = cur_valid_q;
	assign pixel        = cur_q.pix[idx_q];
	assign last_of_run  = at_last;
	assign end_of_line  = at_last && cur_q.eol;
	assign end_of_frame = at_last && cur_q.eof;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (cur_valid_q && out_ready) begin
			if (at_last) begin
				cur_valid_q <= 1'b0;
				idx_q       <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (idx_q <= cur_q.last_idx))
		else $error("pixel index ran past the group");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_valid_q && !out_ready) |=> (cur_valid_q && $stable(idx_q)))
		else $error("pixel position moved while stalled");

endmodule

>>> src/raw10_packed_pixel_unpacker_top.sv
// Top level of the RAW10 packed pixel unpacker with its configuration registers.
//
// Channel  Dir  Handshake            Word
// input    in   in_valid/in_ready    data_byte
// output   out  out_valid/out_ready  pixel, last_of_run, end_of_line, end_of_frame
// config   in   wr_en                wr_index, wr_data
//
// One byte is taken per cycle while in_ready is high; a five-byte group yields up to four
// pixels, one per cycle while out_ready is high. With the pixel side idle, the
// group is registered in the queue and then in cur_q before its first pixel is shown.
// Reset clears the counts and sets the line width to 1456 and the frame height to 1088.
// A two-entry group queue lets the byte side run on while the pixel side is stalled.
module raw10_packed_pixel_unpacker_top
	import r10u_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    data_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIX_W-1:0]     pixel,
	output logic                 last_of_run,
	output logic                 end_of_line,
	output logic                 end_of_frame,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	logic [CFG_W-1:0] line_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic             q_full;
	logic             q_not_empty;
	logic             push;
	logic             pop;
	group_t           push_grp;
	group_t           q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= RESET_LINE_WIDTH;
			frame_height_q <= RESET_FRAME_HEIGHT;
		end else if (wr_en) begin
			case (wr_index)
				REG_LINE_WIDTH:   line_width_q   <= wr_data;
				REG_FRAME_HEIGHT: frame_height_q <= wr_data;
				default: ;
			endcase
		end
	end

	r10u_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.line_width   (line_width_q),
		.frame_height (frame_height_q),
		.q_full       (q_full),
		.push         (push),
		.grp          (push_grp)
	);

	r10u_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_grp  (push_grp),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	r10u_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel        (pixel),
		.last_of_run  (last_of_run),
		.end_of_line  (end_of_line),
		.end_of_frame (end_of_frame)
	);

endmodule
